@@ hdl/clock_second_chance_cache_top_macros.svh @@
// Assertion macros for the second-chance cache.
`ifndef CLOCK_SECOND_CHANCE_CACHE_TOP_MACROS_SVH
`define CLOCK_SECOND_CHANCE_CACHE_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that a condition implies another in the next cycle.
`define CSC_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ hdl/csc_pkg.sv @@
// Types, constants and codes shared by the second-chance cache modules.
package csc_pkg;

    localparam int SLOTS    = 16;
    localparam int KEY_BITS = 32;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int PER_W    = 16;
    localparam int CFG_W    = 16;

    localparam logic [CNT_W-1:0] ACTIVE_RESET = CNT_W'(SLOTS);
    localparam logic [PER_W-1:0] SWEEP_RESET  = PER_W'(500);

    localparam logic [1:0] CMD_GET   = 2'd0;
    localparam logic [1:0] CMD_PUT   = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;
    localparam logic [1:0] CMD_PROBE = 2'd3;

    localparam logic CFG_ACTIVE_SLOTS = 1'b0;
    localparam logic CFG_SWEEP_PERIOD = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_FREE,
        S_SWEEP,
        S_EVICT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]          command;
        logic [KEY_BITS-1:0] key;
    } t_in;

    typedef struct packed {
        logic                hit;
        logic [SLOT_W-1:0]   slot;
        logic [KEY_BITS-1:0] result_key;
        logic                evicted;
        logic [KEY_BITS-1:0] evicted_key;
        logic [CNT_W-1:0]    occupancy;
    } t_out;

    typedef struct packed {
        logic [CNT_W-1:0] ring;
        logic [PER_W-1:0] period;
        logic             flush;
    } t_cfg;

    typedef struct packed {
        logic idle;
        logic res_vld;
    } t_ctl_stat;

    typedef struct packed {
        logic                we;
        logic [SLOT_W-1:0]   waddr;
        logic [KEY_BITS-1:0] wdata;
        logic [SLOT_W-1:0]   raddr;
    } t_mem_req;

endpackage

@@ hdl/csc_key_mem.sv @@
// Key store: one write port, one registered read port.
module csc_key_mem (
    input  logic                         i_clk,
    input  csc_pkg::t_mem_req            i_req,
    output logic [csc_pkg::KEY_BITS-1:0] o_rdata
);
    import csc_pkg::*;

    logic [KEY_BITS-1:0] r_mem [SLOTS];
    logic [KEY_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/csc_ctrl.sv @@
// Sequencer: key scan, free-slot walk, second-chance sweep and aging.
module csc_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  csc_pkg::t_cfg                i_cfg,
    input  logic                         i_in_valid,
    input  csc_pkg::t_in                 i_in,
    input  logic                         i_out_free,
    input  logic [csc_pkg::KEY_BITS-1:0] i_rdata,
    output csc_pkg::t_mem_req            o_mem,
    output csc_pkg::t_ctl_stat           o_stat,
    output csc_pkg::t_out                o_res
);
    import csc_pkg::*;

    t_state              r_state, n_state;
    logic [1:0]          r_cmd, n_cmd;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic                r_pend, n_pend;
    logic [SLOT_W-1:0]   r_pidx, n_pidx;
    logic [SLOT_W-1:0]   r_hand, n_hand;
    logic [SLOT_W-1:0]   r_step, n_step;
    logic [SLOTS-1:0]    r_valid, n_valid;
    logic [SLOTS-1:0]    r_ref, n_ref;
    logic [CNT_W-1:0]    r_filled, n_filled;
    logic [PER_W-1:0]    r_tick, n_tick;
    t_out                r_res, n_res;

    logic [CNT_W-1:0]    w_last;
    logic [CNT_W-1:0]    w_hand_inc;
    logic [SLOT_W-1:0]   w_hand_adv;
    logic [PER_W-1:0]    w_period;
    logic [PER_W-1:0]    w_tick_inc;
    logic                w_match;

    // Shared key comparator and hand stepper.
    assign w_last     = i_cfg.ring - CNT_W'(1);
    assign w_hand_inc = {1'b0, r_hand} + CNT_W'(1);
    assign w_hand_adv = (w_hand_inc == i_cfg.ring) ? '0 : w_hand_inc[SLOT_W-1:0];
    assign w_period   = (i_cfg.period == '0) ? PER_W'(1) : i_cfg.period;
    assign w_tick_inc = r_tick + PER_W'(1);
    assign w_match    = r_pend && r_valid[r_pidx] && (i_rdata == r_key);

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_key    = r_key;
        n_idx    = r_idx;
        n_pend   = r_pend;
        n_pidx   = r_pidx;
        n_hand   = r_hand;
        n_step   = r_step;
        n_valid  = r_valid;
        n_ref    = r_ref;
        n_filled = r_filled;
        n_tick   = r_tick;
        n_res    = r_res;

        o_mem.we    = 1'b0;
        o_mem.waddr = r_hand;
        o_mem.wdata = r_key;
        o_mem.raddr = r_idx[SLOT_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd  = i_in.command;
                    n_key  = i_in.key;
                    n_idx  = '0;
                    n_pend = 1'b0;
                    if ({1'b0, r_hand} >= i_cfg.ring) begin
                        n_hand = '0;
                    end
                    n_res           = '0;
                    n_res.occupancy = r_filled;
                    if (i_in.command == CMD_TICK) begin
                        if (w_tick_inc >= w_period) begin
                            n_ref  = '0;
                            n_tick = '0;
                        end else begin
                            n_tick = w_tick_inc;
                        end
                        n_state = S_DONE;
                    end else begin
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                // Issue one read per cycle, compare the one returned.
                n_pend = ({1'b0, r_idx[SLOT_W-1:0]} == r_idx) && (r_idx < i_cfg.ring);
                n_pidx = r_idx[SLOT_W-1:0];
                if (r_idx < i_cfg.ring) begin
                    n_idx = r_idx + CNT_W'(1);
                end
                if (w_match) begin
                    n_res.hit  = 1'b1;
                    n_res.slot = r_pidx;
                    if (r_cmd == CMD_GET) begin
                        n_res.result_key = r_key;
                    end
                    if (r_cmd != CMD_PROBE) begin
                        n_ref[r_pidx] = 1'b1;
                    end
                    n_pend  = 1'b0;
                    n_state = S_DONE;
                end else if (r_pend && ({1'b0, r_pidx} == w_last)) begin
                    n_pend = 1'b0;
                    n_step = '0;
                    if (r_cmd == CMD_PUT) begin
                        n_state = S_FREE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FREE: begin
                if (!r_valid[r_hand]) begin
                    o_mem.we        = 1'b1;
                    n_valid[r_hand] = 1'b1;
                    n_ref[r_hand]   = 1'b1;
                    n_filled        = r_filled + CNT_W'(1);
                    n_hand          = w_hand_adv;
                    n_res.slot      = r_hand;
                    n_res.occupancy = r_filled + CNT_W'(1);
                    n_state         = S_DONE;
                end else begin
                    n_hand = w_hand_adv;
                    if ({1'b0, r_step} == w_last) begin
                        n_state = S_SWEEP;
                    end else begin
                        n_step = r_step + SLOT_W'(1);
                    end
                end
            end
            S_SWEEP: begin
                // Hold the hand on the victim so its key comes back next cycle.
                o_mem.raddr = r_hand;
                if (!r_ref[r_hand]) begin
                    n_state = S_EVICT;
                end else begin
                    n_ref[r_hand] = 1'b0;
                    n_hand        = w_hand_adv;
                end
            end
            S_EVICT: begin
                o_mem.we          = 1'b1;
                n_valid[r_hand]   = 1'b1;
                n_ref[r_hand]     = 1'b1;
                n_hand            = w_hand_adv;
                n_res.slot        = r_hand;
                n_res.evicted     = 1'b1;
                n_res.evicted_key = i_rdata;
                n_res.occupancy   = r_filled;
                n_state           = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Resizing the ring empties the cache.
        if (i_cfg.flush) begin
            n_valid  = '0;
            n_ref    = '0;
            n_hand   = '0;
            n_filled = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend   <= 1'b0;
            r_hand   <= '0;
            r_valid  <= '0;
            r_ref    <= '0;
            r_filled <= '0;
            r_tick   <= '0;
        end else begin
            r_state  <= n_state;
            r_pend   <= n_pend;
            r_hand   <= n_hand;
            r_valid  <= n_valid;
            r_ref    <= n_ref;
            r_filled <= n_filled;
            r_tick   <= n_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_key  <= n_key;
        r_idx  <= n_idx;
        r_pidx <= n_pidx;
        r_step <= n_step;
        r_res  <= n_res;
    end

    assign o_stat.idle    = (r_state == S_IDLE);
    assign o_stat.res_vld = (r_state == S_DONE);
    assign o_res          = r_res;

endmodule

@@ hdl/clock_second_chance_cache_top.sv @@
// Top level of the second-chance cache: configuration, sequencer, key store, output register.
// Fully associative cache of 16 key slots with CLOCK replacement. One command is taken at a
// time; the key store is scanned one slot per cycle through its single read port. A put
// miss adds the free-slot walk (one slot per cycle) and, on a full ring, the second-chance
// sweep plus a fetch of the evicted key. A finished result waits in the output register
// while the next command is taken. Configuration writes are always ready; a write to
// active_slots empties the cache.
`include "clock_second_chance_cache_top_macros.svh"

module clock_second_chance_cache_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  csc_pkg::t_in              i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output csc_pkg::t_out             o_out_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_index,
    input  logic [csc_pkg::CFG_W-1:0] i_cfg_data
);
    import csc_pkg::*;

    logic [CNT_W-1:0]    r_active;
    logic [PER_W-1:0]    r_period;
    logic                r_out_vld;
    t_out                r_out;

    t_cfg                w_cfg;
    t_ctl_stat           w_stat;
    t_out                w_res;
    t_mem_req            w_mem;
    logic [KEY_BITS-1:0] w_rdata;
    logic                w_cfg_we;
    logic                w_out_free;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
            r_period <= SWEEP_RESET;
        end else if (w_cfg_we) begin
            case (i_cfg_index)
                CFG_ACTIVE_SLOTS: r_active <= i_cfg_data[CNT_W-1:0];
                CFG_SWEEP_PERIOD: r_period <= i_cfg_data[PER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp the ring length to 1..SLOTS.
    always_comb begin
        if (r_active == '0) begin
            w_cfg.ring = CNT_W'(1);
        end else if (r_active > CNT_W'(SLOTS)) begin
            w_cfg.ring = CNT_W'(SLOTS);
        end else begin
            w_cfg.ring = r_active;
        end
        w_cfg.period = r_period;
        w_cfg.flush  = w_cfg_we && (i_cfg_index == CFG_ACTIVE_SLOTS);
    end

    assign w_out_free = !r_out_vld || i_out_ready;
    assign o_in_ready = w_stat.idle;

    csc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_in_valid (i_in_valid),
        .i_in       (i_in_data),
        .i_out_free (w_out_free),
        .i_rdata    (w_rdata),
        .o_mem      (w_mem),
        .o_stat     (w_stat),
        .o_res      (w_res)
    );

    csc_key_mem u_key_mem (
        .i_clk   (i_clk),
        .i_req   (w_mem),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_stat.res_vld && w_out_free) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stat.res_vld && w_out_free) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    `CSC_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "ready after transfer")
    `CSC_ASSERT(a_occ_bound, o_out_valid |-> (o_out_data.occupancy <= w_cfg.ring), "occupancy above ring")
    `CSC_ASSERT(a_evict_full, (o_out_valid && o_out_data.evicted) |-> (!o_out_data.hit && o_out_data.occupancy == w_cfg.ring), "eviction on a ring that is not full")

endmodule

@@ tb/tb_clock_second_chance_cache_top.sv @@
// Self-checking testbench for the second-chance cache top level.
module tb_clock_second_chance_cache_top;
    import csc_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int SETTLE_CYCLES = 3 * SLOTS + 8;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int ITEMS_PER_SET = 120;
    localparam int NUM_SETTINGS  = 12;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    t_in              i_in_data;
    logic             o_out_valid;
    logic             i_out_ready;
    t_out             o_out_data;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic             i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;

    clock_second_chance_cache_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the cache contents and registers
    logic [KEY_BITS-1:0] shadow_key [SLOTS];
    bit                  shadow_valid [SLOTS];
    bit                  shadow_ref [SLOTS];
    int unsigned         shadow_hand;
    logic [PER_W-1:0]    shadow_ticks;
    logic [CNT_W-1:0]    shadow_fill;
    logic [CNT_W-1:0]    shadow_ring;
    logic [PER_W-1:0]    shadow_period;

    t_out                cache_results_q [$];
    logic [KEY_BITS-1:0] key_pool [SLOTS + 4];
    int                  error_count;
    int                  send_idle_pct;
    int                  recv_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(CLK_PERIOD * 1000000);
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("ERROR at %0t: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
            report_mismatch($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
    endtask

    function automatic void clear_shadow_ring();
        foreach (shadow_key[i]) begin
            shadow_valid[i] = 1'b0;
            shadow_ref[i]   = 1'b0;
        end
        shadow_hand = 0;
        shadow_fill = '0;
    endfunction

    function automatic t_out compute_cache_result(input t_in item);
        t_out        res;
        int unsigned ring_n;
        int unsigned period;
        int unsigned victim;
        int          found;
        bit          placed;
        res = '0;
        ring_n = (shadow_ring == 0) ? 1 : ((shadow_ring > SLOTS) ? SLOTS : shadow_ring);
        if (shadow_hand >= ring_n)
            shadow_hand = 0;
        found = -1;
        for (int i = ring_n - 1; i >= 0; i--)
            if (shadow_valid[i] && shadow_key[i] == item.key)
                found = i;
        case (item.command)
            CMD_TICK: begin
                period = (shadow_period == 0) ? 1 : shadow_period;
                shadow_ticks = shadow_ticks + 1'b1;
                if (shadow_ticks >= period) begin
                    foreach (shadow_ref[i]) shadow_ref[i] = 1'b0;
                    shadow_ticks = '0;
                end
            end
            CMD_GET, CMD_PROBE: begin
                if (found >= 0) begin
                    res.hit  = 1'b1;
                    res.slot = found[SLOT_W-1:0];
                    if (item.command == CMD_GET) begin
                        shadow_ref[found] = 1'b1;
                        res.result_key    = shadow_key[found];
                    end
                end
            end
            CMD_PUT: begin
                if (found >= 0) begin
                    res.hit           = 1'b1;
                    res.slot          = found[SLOT_W-1:0];
                    shadow_ref[found] = 1'b1;
                end else begin
                    placed = 1'b0;
                    for (int i = 0; i < ring_n && !placed; i++) begin
                        if (!shadow_valid[shadow_hand])
                            placed = 1'b1;
                        else
                            shadow_hand = (shadow_hand + 1) % ring_n;
                    end
                    if (placed) begin
                        shadow_fill = shadow_fill + 1'b1;
                    end else begin
                        // ring full: clear reference bits until an unmarked slot turns up
                        for (int i = 0; i < 2 * ring_n && shadow_ref[shadow_hand]; i++) begin
                            shadow_ref[shadow_hand] = 1'b0;
                            shadow_hand = (shadow_hand + 1) % ring_n;
                        end
                        res.evicted     = 1'b1;
                        res.evicted_key = shadow_key[shadow_hand];
                    end
                    victim               = shadow_hand;
                    shadow_key[victim]   = item.key;
                    shadow_valid[victim] = 1'b1;
                    shadow_ref[victim]   = 1'b1;
                    shadow_hand          = (victim + 1) % ring_n;
                    res.slot             = victim[SLOT_W-1:0];
                end
            end
        endcase
        res.occupancy = shadow_fill;
        return res;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_cmd(input logic [1:0] cmd, input logic [KEY_BITS-1:0] key);
        t_in item;
        item.command = cmd;
        item.key     = key;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        cache_results_q.push_back(compute_cache_result(item));
        @(negedge i_clk);
    endtask

    // Hold off the sender until every pending result is back, then settle.
    task automatic await_results(input int settle);
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (cache_results_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (cache_results_q.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", cache_results_q.size()));
            cache_results_q.delete();
        end
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_ACTIVE_SLOTS) begin
            shadow_ring = data[CNT_W-1:0];
            clear_shadow_ring();
        end else begin
            shadow_period = data[PER_W-1:0];
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] ring, input logic [CFG_W-1:0] period);
        await_results(SETTLE_CYCLES);
        write_reg(CFG_SWEEP_PERIOD, period);
        write_reg(CFG_ACTIVE_SLOTS, ring);
    endtask

    task automatic test_defaults_after_reset();
        send_cmd(CMD_PROBE, '0);
        send_cmd(CMD_GET, '1);
        send_cmd(CMD_PUT, '0);
        send_cmd(CMD_PUT, '1);
        send_cmd(CMD_GET, '1);
        send_cmd(CMD_PROBE, '0);
        send_cmd(CMD_PUT, '0);
        send_cmd(CMD_TICK, '1);
    endtask

    task automatic test_second_chance_eviction();
        configure(2, 500);
        send_cmd(CMD_PUT, 32'h0000_00A5);
        send_cmd(CMD_PUT, 32'h5A5A_0001);
        send_cmd(CMD_PUT, 32'hDEAD_BEEF);
        send_cmd(CMD_PROBE, 32'h0000_00A5);
        send_cmd(CMD_GET, 32'hDEAD_BEEF);
        send_cmd(CMD_PUT, 32'h8000_0000);
        send_cmd(CMD_GET, 32'h5A5A_0001);
    endtask

    task automatic test_aging_and_period();
        configure(2, 2);
        send_cmd(CMD_PUT, 32'h1111_0000);
        send_cmd(CMD_PUT, 32'h2222_0000);
        send_cmd(CMD_TICK, '0);
        send_cmd(CMD_TICK, '0);
        // all marks cleared, so the next miss takes the hand slot at once
        send_cmd(CMD_PUT, 32'h3333_0000);
        await_results(SETTLE_CYCLES);
        write_reg(CFG_SWEEP_PERIOD, 10);
        send_cmd(CMD_GET, 32'h2222_0000);
        repeat (4) send_cmd(CMD_TICK, '0);
        // drop the period below the running count; the next tick must age
        await_results(SETTLE_CYCLES);
        write_reg(CFG_SWEEP_PERIOD, 2);
        send_cmd(CMD_TICK, '0);
        send_cmd(CMD_PUT, 32'h4444_0000);
    endtask

    task automatic test_random_traffic();
        int unsigned ring_set [NUM_SETTINGS]   = '{16, 1, 4, 8, 0, 20, 31, 2, 12, 5, 16, 3};
        int unsigned period_set [NUM_SETTINGS] = '{3, 1, 2, 5, 65535, 0, 7, 1, 4, 3, 1, 2};
        logic [CFG_W-1:0] ring_word;
        int unsigned ring_n;
        int unsigned pick;
        logic [1:0]  cmd;
        logic [KEY_BITS-1:0] key;
        for (int s = 0; s < NUM_SETTINGS; s++) begin
            ring_word = ring_set[s];
            if (s == 8)
                ring_word = ring_word | 16'hFFE0;
            configure(ring_word, period_set[s]);
            case (s % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            ring_n = (ring_set[s] == 0) ? 1 : ((ring_set[s] > SLOTS) ? SLOTS : ring_set[s]);
            foreach (key_pool[i]) key_pool[i] = $urandom();
            key_pool[0] = '0;
            key_pool[1] = '1;
            for (int k = 0; k < ITEMS_PER_SET; k++) begin
                pick = $urandom_range(99);
                if (pick < 40)      cmd = CMD_PUT;
                else if (pick < 65) cmd = CMD_GET;
                else if (pick < 80) cmd = CMD_PROBE;
                else                cmd = CMD_TICK;
                if ($urandom_range(99) < 85)
                    key = key_pool[$urandom_range(ring_n + 3)];
                else
                    key = $urandom();
                send_cmd(cmd, key);
                if ($urandom_range(49) == 0)
                    await_results(0);
            end
        end
    endtask

    // Randomize backpressure on the result channel
    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (cache_results_q.size() == 0) begin
                report_mismatch("result transfer with no command pending");
            end else begin
                want = cache_results_q.pop_front();
                check_field("hit", want.hit, o_out_data.hit);
                check_field("slot", want.slot, o_out_data.slot);
                check_field("result_key", want.result_key, o_out_data.result_key);
                check_field("evicted", want.evicted, o_out_data.evicted);
                check_field("evicted_key", want.evicted_key, o_out_data.evicted_key);
                check_field("occupancy", want.occupancy, o_out_data.occupancy);
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_out_ready    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_ACTIVE_SLOTS;
        i_cfg_data     = '0;
        error_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        shadow_ring    = ACTIVE_RESET;
        shadow_period  = SWEEP_RESET;
        shadow_ticks   = '0;
        clear_shadow_ring();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_defaults_after_reset();
        test_second_chance_eviction();
        test_aging_and_period();
        test_random_traffic();

        await_results(SETTLE_CYCLES);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
